@@ hdl/sliding_window_min_max_mean_macros.svh @@
// assertion macros for the sliding window min/max/mean block
// used by the port checker; no other dependencies
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH

// same-cycle implication
`define SWMMM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWMMM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/swmmm_pkg.sv @@
// shared constants, types and control structs for the sliding window block
// no dependencies
`default_nettype none

package swmmm_pkg;

	localparam int DEPTH     = 64;
	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 7;
	localparam int HELD_W    = 7;
	localparam int LEN_RESET = (64 > DEPTH) ? DEPTH : 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int SUM_W     = SAMPLE_W + CNT_W;
	localparam int DIV_W     = SUM_W + (SUM_W % 2);
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DSTEP_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int IN_W      = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_BITS  = 3 * SAMPLE_W + HELD_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_LAST,
		ST_DIVLD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic idle;
		logic wr;
		logic scan;
		logic last;
		logic div_ld;
		logic div_step;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ hdl/swmmm_ctrl.sv @@
// sequencing state machine for the sliding window block
// depends on swmmm_pkg
`default_nettype none

module swmmm_ctrl
	import swmmm_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_WRITE;
			end
			ST_WRITE: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_last) state_nxt = ST_LAST;
			end
			ST_LAST:  state_nxt = ST_DIVLD;
			ST_DIVLD: state_nxt = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.idle     = 1'b1;
			ST_WRITE: cmd.wr       = 1'b1;
			ST_SCAN:  cmd.scan     = 1'b1;
			ST_LAST:  cmd.last     = 1'b1;
			ST_DIVLD: cmd.div_ld   = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_DONE:  cmd.out_ld   = stat.out_free;
			default:  cmd          = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/swmmm_dp.sv @@
// datapath: sample ring, window scan for sum/min/max, serial divider, result register
// depends on swmmm_pkg
`default_nettype none

module swmmm_dp
	import swmmm_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  wire                 in_valid,
	input  wire  [SAMPLE_W-1:0] sample,
	input  wire                 cfg_valid,
	input  wire  [LEN_W-1:0]    cfg_data,
	input  wire                 out_ready,
	output logic                out_valid,
	output logic [OUT_W-1:0]    out_data
);

	logic        [SAMPLE_W-1:0] mem [DEPTH];
	logic        [SAMPLE_W-1:0] sample_q;
	logic        [CNT_W-1:0]    len_q;
	logic        [ADDR_W-1:0]   pos_q;
	logic        [CNT_W-1:0]    fill_q;
	logic        [CNT_W-1:0]    rd_idx_q;
	logic signed [SAMPLE_W-1:0] rd_data_s1;
	logic                       rd_vld_s1;
	logic                       first_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic                       neg_q;
	logic        [CNT_W-1:0]    rem_q;
	logic        [DIV_W-1:0]    quo_q;
	logic        [DSTEP_W-1:0]  div_cnt_q;
	logic                       out_valid_q;
	logic        [SAMPLE_W-1:0] mean_q;
	logic        [SAMPLE_W-1:0] omin_q;
	logic        [SAMPLE_W-1:0] omax_q;
	logic        [HELD_W-1:0]   held_q;

	logic        [CNT_W-1:0]    len_new;
	logic        [ADDR_W-1:0]   wpos;
	logic        [CNT_W-1:0]    pos_inc;
	logic        [SUM_W-1:0]    sum_mag;
	logic        [CNT_W+DIV_W-1:0] step_a;
	logic        [CNT_W+DIV_W-1:0] step_b;
	logic        [SAMPLE_W-1:0] quo_lo;
	logic                       cfg_wr;

	function automatic logic [CNT_W+DIV_W-1:0] div_bit(
		input logic [CNT_W-1:0] rem,
		input logic [DIV_W-1:0] quo,
		input logic [CNT_W-1:0] dvs
	);
		logic [CNT_W:0] trial;
		logic           qbit;
		trial = {rem, quo[DIV_W-1]};
		qbit  = 1'b0;
		if (trial >= {1'b0, dvs}) begin
			trial = trial - {1'b0, dvs};
			qbit  = 1'b1;
		end
		return {trial[CNT_W-1:0], quo[DIV_W-2:0], qbit};
	endfunction

	assign cfg_wr = cfg_valid & cmd.idle;

	always_comb begin
		if (cfg_data == '0) begin
			len_new = CNT_W'(1);
		end else if (32'(cfg_data) > DEPTH) begin
			len_new = CNT_W'(DEPTH);
		end else begin
			len_new = CNT_W'(cfg_data);
		end
	end

	assign wpos    = (CNT_W'(pos_q) >= len_q) ? '0 : pos_q;
	assign pos_inc = CNT_W'(wpos) + CNT_W'(1);
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign step_a  = div_bit(rem_q, quo_q, fill_q);
	assign step_b  = div_bit(step_a[CNT_W+DIV_W-1:DIV_W], step_a[DIV_W-1:0], fill_q);
	assign quo_lo  = quo_q[SAMPLE_W-1:0];

	assign stat.scan_last = (rd_idx_q == fill_q - CNT_W'(1));
	assign stat.div_last  = (div_cnt_q == '0);
	assign stat.out_free  = ~out_valid_q | out_ready;

	// ring store and registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wpos] <= sample_q;
		end
		rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.idle && in_valid) begin
			sample_q <= sample;
		end
		if (cmd.wr) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
			if (first_q || rd_data_s1 < min_q) min_q <= rd_data_s1;
			if (first_q || rd_data_s1 > max_q) max_q <= rd_data_s1;
		end
		if (cmd.div_ld) begin
			neg_q <= sum_q[SUM_W-1];
			rem_q <= '0;
			quo_q <= DIV_W'(sum_mag);
		end else if (cmd.div_step) begin
			rem_q <= step_b[CNT_W+DIV_W-1:DIV_W];
			quo_q <= step_b[DIV_W-1:0];
		end
		if (cmd.out_ld) begin
			mean_q <= neg_q ? (~quo_lo + SAMPLE_W'(1)) : quo_lo;
			omin_q <= min_q;
			omax_q <= max_q;
			held_q <= HELD_W'(fill_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= CNT_W'(LEN_RESET);
			pos_q       <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			first_q     <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cfg_wr) begin
				len_q  <= len_new;
				pos_q  <= '0;
				fill_q <= '0;
			end else if (cmd.wr) begin
				pos_q <= (pos_inc >= len_q) ? '0 : ADDR_W'(pos_inc);
				if (fill_q < len_q) fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.wr) begin
				rd_idx_q <= '0;
				first_q  <= 1'b1;
			end else begin
				if (cmd.scan) rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (rd_vld_s1) first_q <= 1'b0;
			end
			if (cmd.div_ld) begin
				div_cnt_q <= DSTEP_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DSTEP_W'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = OUT_W'({held_q, omax_q, omin_q, mean_q});

endmodule

`default_nettype wire

@@ hdl/sliding_window_min_max_mean.sv @@
// one request at a time: s_tready stays low until the result of the accepted one is loaded
// the work per request is the one-entry-per-cycle scan of the n samples held (1..64)
// in the sample ram and a 2 bit per cycle divider
// a finished result waits in the output register while the next request is taken
// reset: arst_n clears count, write position and handshakes; window_length returns to 64
`default_nettype none

module sliding_window_min_max_mean
	import swmmm_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [IN_W-1:0]  s_tdata,   // sample
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [OUT_W-1:0] m_tdata,   // mean_value, min_value, max_value, held_count
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [LEN_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	swmmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	swmmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_valid  (s_tvalid),
		.sample    (s_tdata[SAMPLE_W-1:0]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	assign s_tready  = cmd.idle;
	assign cfg_ready = cmd.idle;

endmodule

`default_nettype wire

@@ hdl/swmmm_checker.sv @@
// port level checks for the sliding window block, bound to the top level
// depends on swmmm_pkg and sliding_window_min_max_mean_macros.svh
`default_nettype none
`include "sliding_window_min_max_mean_macros.svh"

module swmmm_checker
	import swmmm_pkg::*;
(
	input wire             clk,
	input wire             arst_n,
	input wire             s_tvalid,
	input wire             s_tready,
	input wire             m_tvalid,
	input wire             m_tready,
	input wire [OUT_W-1:0] m_tdata
);

	logic signed [SAMPLE_W-1:0] mean_f;
	logic signed [SAMPLE_W-1:0] min_f;
	logic signed [SAMPLE_W-1:0] max_f;
	logic        [HELD_W-1:0]   held_f;

	assign mean_f = m_tdata[SAMPLE_W-1:0];
	assign min_f  = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign max_f  = m_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
	assign held_f = m_tdata[OUT_BITS-1:3*SAMPLE_W];

	`SWMMM_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
	`SWMMM_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`SWMMM_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`SWMMM_ASSERT_IMP(a_held_range, clk, arst_n, m_tvalid, held_f != '0 && 32'(held_f) <= DEPTH, "held count out of range")
	`SWMMM_ASSERT_IMP(a_mean_bounds, clk, arst_n, m_tvalid, min_f <= mean_f && mean_f <= max_f, "mean outside min/max")

endmodule

bind sliding_window_min_max_mean swmmm_checker u_chk (.*);

`default_nettype wire
